[sv/ovn_pkg.sv]
// Package for the octave value noise block: field widths, register indices,
// lattice hash constants and the sequencer state type. No dependencies.
package ovn_pkg;

  localparam int POSITION_W  = 24;
  localparam int NOISE_W     = 32;
  localparam int COUNT_W     = 5;
  localparam int PERSIST_W   = 17;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_OCTAVE_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PERSISTENCE  = CFG_INDEX_W'(1);

  localparam logic [COUNT_W-1:0]   OCTAVE_COUNT_RESET = COUNT_W'(8);
  localparam logic [PERSIST_W-1:0] PERSIST_RESET      = PERSIST_W'(32768);
  localparam logic [PERSIST_W-1:0] AMP_ONE            = PERSIST_W'(65536);

  // Lattice hash and value mapping.
  localparam int LATTICE_W = 32;
  localparam int HASH_SHIFT = 13;
  localparam logic [LATTICE_W-1:0] HASH_MUL_A  = 32'd15731;
  localparam logic [LATTICE_W-1:0] HASH_ADD_B  = 32'd789221;
  localparam logic [LATTICE_W-1:0] HASH_ADD_C  = 32'd1376312589;
  localparam logic [LATTICE_W-1:0] LATTICE_ONE = 32'h4000_0000;

  // Shared multiplier: signed operands, full product.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = 34;
  localparam int TERM_SHIFT = 22;
  localparam int AMP_SHIFT  = 16;

  // Octave accumulator, wide enough for 32 octaves without wrap.
  localparam int TOTAL_W = 40;
  localparam logic signed [TOTAL_W-1:0] SAT_HI = {{(TOTAL_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [TOTAL_W-1:0] SAT_LO = {{(TOTAL_W-31){1'b1}}, {31{1'b0}}};

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_H_SQ   = 12'b0000_0000_0010,
    ST_H_MC   = 12'b0000_0000_0100,
    ST_H_MX   = 12'b0000_0000_1000,
    ST_H_FIN  = 12'b0000_0001_0000,
    ST_H_ACC  = 12'b0000_0010_0000,
    ST_L_DIFF = 12'b0000_0100_0000,
    ST_L_NORM = 12'b0000_1000_0000,
    ST_L_AMP  = 12'b0001_0000_0000,
    ST_L_SUM  = 12'b0010_0000_0000,
    ST_L_PERS = 12'b0100_0000_0000,
    ST_FINISH = 12'b1000_0000_0000
  } state_t;

endpackage

[sv/octave_value_noise_1d_top.sv]
// Fractal 1D value noise: octave sum of smoothed, interpolated lattice noise.
// Depends on ovn_pkg for widths, register indices, hash constants and states.
//
//   Input channel (in_valid/in_ready/position) takes one Q8.16 position per
//   transfer; output channel (out_valid/out_ready/noise_value) returns one
//   signed Q8.24 sample per input, in order.
//   Configuration (cfg_we/cfg_index/cfg_data) sets octave_count (index 0) and
//   persistence (index 1); other indices are ignored. Write only while idle.
//   The octave count is clamped to MAX_OCTAVES, and a new position is taken
//   only once the previous one has been through every octave. Each octave
//   hashes four lattice points through the single 33x33 multiplier, then
//   uses the same multiplier for interpolation, weighting and the amplitude
//   update. With zero octaves the sequencer goes from idle straight to its
//   final step.
//   in_ready is high only while the sequencer is idle; a finished result sits
//   in the output register, so the next position can be taken while it waits.
//   If the receiver stalls and the previous result is still held, the
//   sequencer waits in its final step until the output register is free.
//   Reset clears out_valid, returns to idle and restores the register
//   defaults (8 octaves, persistence 0.5).
module octave_value_noise_1d_top
  import ovn_pkg::*;
#(
  parameter int MAX_OCTAVES   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [POSITION_W-1:0]     position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [NOISE_W-1:0] noise_value
);

  localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
  localparam int SH_W  = FRACTION_BITS + LATTICE_W;

  state_t state;

  logic [COUNT_W-1:0]   octave_count;
  logic [PERSIST_W-1:0] persistence;

  logic [CNT_W-1:0]     oct_total;
  logic [CNT_W-1:0]     k;
  logic [1:0]           pt;
  logic [SH_W-1:0]      pos_sh;
  logic [PERSIST_W-1:0] amp;
  logic [LATTICE_W-1:0] xreg;
  logic signed [LATTICE_W-1:0] vreg;
  logic signed [SUM_W-1:0]     s_a;
  logic signed [SUM_W-1:0]     s_b;
  logic signed [MUL_W-1:0]     nreg;
  logic signed [TOTAL_W-1:0]   total;
  logic signed [PROD_W-1:0]    prod;

  logic [CNT_W-1:0]            count_eff;
  logic [PERSIST_W-1:0]        pers_eff;
  logic [LATTICE_W-1:0]        lat_i;
  logic [FRACTION_BITS-1:0]    frac;
  logic [LATTICE_W-1:0]        xi;
  logic [LATTICE_W-1:0]        x;
  logic [LATTICE_W-1:0]        hsum;
  logic signed [LATTICE_W-1:0] v_new;
  logic signed [SUM_W-1:0]     vext;
  logic signed [SUM_W-1:0]     v2;
  logic signed [LATTICE_W-1:0] sa_q;
  logic signed [LATTICE_W-1:0] sb_q;
  logic signed [MUL_W-1:0]     diff;
  logic signed [MUL_W-1:0]     frac_term;
  logic signed [TOTAL_W-1:0]   term;
  logic signed [MUL_W-1:0]     mul_a;
  logic signed [MUL_W-1:0]     mul_b;
  logic                        mul_en;
  logic [CNT_W-1:0]            k_inc;
  logic signed [NOISE_W-1:0]   sat_total;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    if (octave_count > MAX_OCTAVES) begin
      count_eff = CNT_W'(MAX_OCTAVES);
    end else begin
      count_eff = CNT_W'(octave_count);
    end
    if (persistence > AMP_ONE) begin
      pers_eff = AMP_ONE;
    end else begin
      pers_eff = persistence;
    end
  end

  // Lattice point pt of the current octave is i - 1 + pt.
  assign lat_i = pos_sh[FRACTION_BITS +: LATTICE_W];
  assign frac  = pos_sh[FRACTION_BITS-1:0];
  assign xi    = lat_i + {{(LATTICE_W-2){1'b0}}, pt} - LATTICE_W'(1);
  assign x     = xi ^ (xi << HASH_SHIFT);

  assign hsum  = prod[LATTICE_W-1:0] + HASH_ADD_C;
  assign v_new = signed'(LATTICE_ONE - {1'b0, hsum[LATTICE_W-2:0]});
  assign vext  = SUM_W'(vreg);
  assign v2    = vext <<< 1;

  // An arithmetic shift by two is the floor of the quarter-weighted sum.
  assign sa_q      = s_a[SUM_W-1:2];
  assign sb_q      = s_b[SUM_W-1:2];
  assign diff      = MUL_W'(sb_q) - MUL_W'(sa_q);
  assign frac_term = prod[FRACTION_BITS +: MUL_W];
  assign term      = prod[TERM_SHIFT +: TOTAL_W];
  assign k_inc     = k + CNT_W'(1);

  always_comb begin
    if (total > SAT_HI) begin
      sat_total = SAT_HI[NOISE_W-1:0];
    end else if (total < SAT_LO) begin
      sat_total = SAT_LO[NOISE_W-1:0];
    end else begin
      sat_total = total[NOISE_W-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    unique case (state)
      ST_H_SQ: begin
        mul_a  = {1'b0, x};
        mul_b  = {1'b0, x};
        mul_en = 1'b1;
      end
      ST_H_MC: begin
        mul_a  = {1'b0, prod[LATTICE_W-1:0]};
        mul_b  = {1'b0, HASH_MUL_A};
        mul_en = 1'b1;
      end
      ST_H_MX: begin
        mul_a  = {1'b0, prod[LATTICE_W-1:0] + HASH_ADD_B};
        mul_b  = {1'b0, xreg};
        mul_en = 1'b1;
      end
      ST_L_DIFF: begin
        mul_a  = diff;
        mul_b  = {{(MUL_W-FRACTION_BITS){1'b0}}, frac};
        mul_en = 1'b1;
      end
      ST_L_AMP: begin
        mul_a  = nreg;
        mul_b  = {{(MUL_W-PERSIST_W){1'b0}}, amp};
        mul_en = 1'b1;
      end
      ST_L_SUM: begin
        mul_a  = {{(MUL_W-PERSIST_W){1'b0}}, amp};
        mul_b  = {{(MUL_W-PERSIST_W){1'b0}}, pers_eff};
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= OCTAVE_COUNT_RESET;
      persistence  <= PERSIST_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_OCTAVE_COUNT) begin
        octave_count <= cfg_data[COUNT_W-1:0];
      end else if (cfg_index == REG_PERSISTENCE) begin
        persistence <= cfg_data[PERSIST_W-1:0];
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pos_sh    <= SH_W'(position);
        oct_total <= count_eff;
        k         <= '0;
        pt        <= '0;
        amp       <= AMP_ONE;
        total     <= '0;
      end
      ST_H_SQ: begin
        xreg <= x;
      end
      ST_H_FIN: begin
        vreg <= v_new;
      end
      ST_H_ACC: begin
        // Point 0 is i-1, so it opens the left sum and clears the right one.
        case (pt)
          2'd0: begin
            s_a <= vext;
            s_b <= '0;
          end
          2'd1: begin
            s_a <= s_a + v2;
            s_b <= s_b + vext;
          end
          2'd2: begin
            s_a <= s_a + vext;
            s_b <= s_b + v2;
          end
          default: begin
            s_b <= s_b + vext;
          end
        endcase
        pt <= pt + 2'd1;
      end
      ST_L_NORM: begin
        nreg <= MUL_W'(sa_q) + frac_term;
      end
      ST_L_SUM: begin
        total <= total + term;
      end
      ST_L_PERS: begin
        amp    <= prod[AMP_SHIFT +: PERSIST_W];
        k      <= k_inc;
        pos_sh <= pos_sh << 1;
      end
      default: begin
        pt <= pt;
      end
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A finished result may replace the held one in the cycle that one leaves.
      if (state == ST_FINISH && (!out_valid || out_ready)) begin
        out_valid   <= 1'b1;
        noise_value <= sat_total;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= (count_eff == '0) ? ST_FINISH : ST_H_SQ;
          end
        end
        ST_H_SQ:   state <= ST_H_MC;
        ST_H_MC:   state <= ST_H_MX;
        ST_H_MX:   state <= ST_H_FIN;
        ST_H_FIN:  state <= ST_H_ACC;
        ST_H_ACC:  state <= (pt == 2'd3) ? ST_L_DIFF : ST_H_SQ;
        ST_L_DIFF: state <= ST_L_NORM;
        ST_L_NORM: state <= ST_L_AMP;
        ST_L_AMP:  state <= ST_L_SUM;
        ST_L_SUM:  state <= ST_L_PERS;
        ST_L_PERS: state <= (k_inc == oct_total) ? ST_FINISH : ST_H_SQ;
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/ovn_checker.sv]
// Port-level checks for the octave value noise block, with the bind that
// attaches them to octave_value_noise_1d_top. Depends on ovn_pkg for widths.
module ovn_checker
  import ovn_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [NOISE_W-1:0] noise_value
);

  // A held result must not change or vanish while the receiver stalls.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(noise_value))
    else $error("stalled result changed or dropped");

  // After a transfer in, the block is not ready in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample was still in progress");

  // A new result only appears out of a busy period.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a sample in progress");

  // Reset leaves the block idle with no result pending.
  assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind octave_value_noise_1d_top ovn_checker u_ovn_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .noise_value (noise_value)
);

[tb/octave_value_noise_1d_top_tb.sv]
// Testbench for octave_value_noise_1d_top: a short directed table, then randomised phases
// under several register settings and handshake pressures, checked by a fixed-point predictor.
// Depends on ovn_pkg and on the block's RTL; needs nothing else.
module octave_value_noise_1d_top_tb;
  import ovn_pkg::*;

  localparam int MAX_OCT = 16;
  localparam int FRAC_W = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 25 * MAX_OCT + 2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(9);

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [CFG_INDEX_W-1:0]      index;
    logic [CFG_DATA_W-1:0]       data;
    logic [POSITION_W-1:0]       pos;
    logic                        pinned;
    logic signed [NOISE_W-1:0]   pinned_value;
  } row_t;

  typedef struct {
    logic [POSITION_W-1:0]       pos;
    logic signed [NOISE_W-1:0]   value;
  } sample_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [POSITION_W-1:0]     position;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [NOISE_W-1:0] noise_value;

  // Mirror of the block's registers, as written.
  logic [COUNT_W-1:0]   octaves_cfg;
  logic [PERSIST_W-1:0] persist_cfg;

  row_t    directed[$];
  sample_t noise_expected[$];
  sample_t head;
  int      sender_idle_pct;
  int      stall_pct;
  int      mismatches;
  int      items_sent;
  int      results_seen;
  int      quiet_cycles;

  octave_value_noise_1d_top #(
    .MAX_OCTAVES  (MAX_OCT),
    .FRACTION_BITS(FRAC_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .position   (position),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .noise_value(noise_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint lattice_value(input logic [31:0] idx);
    logic [31:0] x;
    logic [31:0] h;
    x = (idx << 13) ^ idx;
    h = (x * (x * x * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
    return 64'sd1073741824 - longint'(h);
  endfunction

  // Arithmetic shift on a signed value rounds toward minus infinity.
  function automatic longint smoothed_value(input logic [31:0] idx);
    return (2 * lattice_value(idx) + lattice_value(idx - 32'd1)
            + lattice_value(idx + 32'd1)) >>> 2;
  endfunction

  function automatic logic signed [NOISE_W-1:0] predict_noise(input logic [POSITION_W-1:0] pos);
    int          octaves;
    longint      amp;
    longint      pers;
    longint      total;
    longint      fr;
    longint      left;
    longint      right;
    longint      blend;
    logic [63:0] scaled;
    logic [31:0] lat_idx;
    octaves = (octaves_cfg > MAX_OCT) ? MAX_OCT : int'(octaves_cfg);
    pers = (persist_cfg > AMP_ONE) ? longint'(AMP_ONE) : longint'(persist_cfg);
    amp = longint'(AMP_ONE);
    total = 0;
    for (int k = 0; k < octaves; k++) begin
      scaled = 64'(pos) << k;
      lat_idx = scaled[FRAC_W+31:FRAC_W];
      fr = longint'(scaled[FRAC_W-1:0]);
      left = smoothed_value(lat_idx);
      right = smoothed_value(lat_idx + 32'd1);
      blend = (left * ((longint'(1) << FRAC_W) - fr) + right * fr) >>> FRAC_W;
      total += (blend * amp) >>> TERM_SHIFT;
      amp = (amp * pers) >>> AMP_SHIFT;
    end
    if (total > longint'(SAT_HI)) total = longint'(SAT_HI);
    if (total < longint'(SAT_LO)) total = longint'(SAT_LO);
    return total[NOISE_W-1:0];
  endfunction

  task automatic add_item(input logic [POSITION_W-1:0] p);
    row_t r;
    r = '{ROW_ITEM, '0, '0, p, 1'b0, '0};
    directed = {directed, r};
  endtask

  task automatic add_pinned(input logic [POSITION_W-1:0] p, input logic signed [NOISE_W-1:0] v);
    row_t r;
    r = '{ROW_ITEM, '0, '0, p, 1'b1, v};
    directed = {directed, r};
  endtask

  task automatic add_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{ROW_WRITE, idx, val, '0, 1'b0, '0};
    directed = {directed, r};
  endtask

  // Called at a falling edge; returns at a falling edge with the write done.
  task automatic set_register(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_OCTAVE_COUNT) octaves_cfg = val[COUNT_W-1:0];
    else if (idx == REG_PERSISTENCE) persist_cfg = val[PERSIST_W-1:0];
  endtask

  // Called at a falling edge. Valid is left high after the transfer, so the caller either
  // offers the next position or lowers valid at the falling edge this task returns on.
  task automatic send_position(input logic [POSITION_W-1:0] p, input logic pinned,
                               input logic signed [NOISE_W-1:0] pinned_value);
    sample_t s;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    position <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    s.pos = p;
    s.value = pinned ? pinned_value : predict_noise(p);
    noise_expected = {noise_expected, s};
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (noise_expected.size() != 0);
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] count, input logic [PERSIST_W-1:0] pers,
                           input int idle_pct, input int stall, input int n);
    logic [CFG_DATA_W-1:0] word;
    logic [POSITION_W-1:0] p;
    wait_drained();
    // Junk above the count field must be dropped by the block.
    word = CFG_DATA_W'($urandom);
    word[COUNT_W-1:0] = count;
    set_register(REG_OCTAVE_COUNT, word);
    set_register(REG_PERSISTENCE, CFG_DATA_W'(pers));
    // A write to an unmapped index must leave both registers alone.
    set_register(CFG_INDEX_W'($urandom_range(REG_PERSISTENCE + 1, (1 << CFG_INDEX_W) - 1)),
                 CFG_DATA_W'($urandom));
    sender_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (n) begin
      p = POSITION_W'($urandom);
      case ($urandom_range(5))
        0: p[FRAC_W-1:0] = '0;
        1: p[FRAC_W-1:0] = '1;
        2: p[FRAC_W-1:4] = '0;
        3: p[POSITION_W-1:FRAC_W] = {(POSITION_W - FRAC_W){$urandom_range(1) == 1}};
        default: ;
      endcase
      send_position(p, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (noise_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d with no position pending", noise_value);
      end else begin
        head = noise_expected.pop_front();
        if (noise_value !== head.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise_value for position 0x%06h: expected %0d, got %0d",
                     head.pos, head.value, noise_value);
        end
      end
    end
  end

  // A transfer on either channel shows the block is still making progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    position = '0;
    out_ready = 1'b0;
    octaves_cfg = OCTAVE_COUNT_RESET;
    persist_cfg = PERSIST_RESET;
    sender_idle_pct = 31;
    stall_pct = 31;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    quiet_cycles = 0;

    // Reset defaults first, then no octaves, a single octave, clamped count and
    // persistence, an ignored register write and the full sixteen octaves.
    add_item(24'h000000);
    add_item(24'hFFFFFF);
    add_item(24'h010000);
    add_item(24'h00FFFF);
    add_item(24'h800000);
    add_write(REG_OCTAVE_COUNT, 17'd0);
    add_pinned(24'h123456, 32'sd0);
    add_pinned(24'hFFFFFF, 32'sd0);
    add_write(REG_OCTAVE_COUNT, 17'd1);
    add_write(REG_PERSISTENCE, 17'd0);
    add_item(24'h000000);
    add_item(24'h00FFFF);
    add_item(24'h010000);
    add_write(REG_OCTAVE_COUNT, 17'd31);
    add_write(REG_PERSISTENCE, 17'h1FFFF);
    add_item(24'hFFFFFF);
    add_item(24'h7FFF80);
    add_write(REG_UNUSED, 17'd0);
    add_item(24'hABCDEF);
    add_write(REG_OCTAVE_COUNT, 17'd16);
    add_write(REG_PERSISTENCE, 17'd65536);
    add_item(24'h000001);
    add_item(24'h5A5A5A);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[r]) begin
      if (directed[r].kind == ROW_WRITE) begin
        wait_drained();
        set_register(directed[r].index, directed[r].data);
      end else begin
        send_position(directed[r].pos, directed[r].pinned, directed[r].pinned_value);
      end
    end

    run_phase(5'd8,  17'd32768,                  0,  0,  150);
    run_phase(5'd16, 17'd65536,                  77, 0,  150);
    run_phase(5'd1,  17'd0,                      0,  77, 150);
    run_phase(5'd0,  17'd12345,                  31, 31, 150);
    run_phase(5'd31, 17'h1FFFF,                  0,  0,  150);
    run_phase(5'd3,  PERSIST_W'($urandom),       77, 0,  150);
    run_phase(5'd12, 17'd45000,                  0,  77, 150);
    run_phase(5'd5,  17'd1,                      31, 31, 150);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d positions and checked %0d noise values over the directed table and",
             items_sent, results_seen);
    $display("eight random phases, from zero to clamped octave counts and persistence up to above one.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
